[rtl/core/mrf_pkg.sv]
package mrf_pkg;

   // Modbus function codes
   localparam logic [7:0] FUNC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FUNC_WRITE_SINGLE   = 8'd6;
   localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'd16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // default depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_READ_HOLDING   = 2'd0,
      OP_WRITE_SINGLE   = 2'd1,
      OP_WRITE_MULTIPLE = 2'd2,
      OP_UNUSED         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SINGLE,      // read or single write, complete frame
      KIND_MULTI_FIRST, // first data word, emits header
      KIND_MULTI_NEXT   // later data word, data bytes only
   } kind_type;

   // byte position inside the emitted sequence
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_SLAVE,
      STEP_FUNC,
      STEP_ADDR_HI,
      STEP_ADDR_LO,
      STEP_VALUE_HI,
      STEP_VALUE_LO,
      STEP_BYTE_COUNT,
      STEP_DATA_HI,
      STEP_DATA_LO,
      STEP_CRC_LO,
      STEP_CRC_HI
   } step_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  func_code;
      logic [7:0]  slave;
      logic [15:0] addr;
      logic [15:0] word;
      logic [6:0]  count;
      logic        last;
   } cmd_type;

   // one byte through the reflected CRC-16, bit at a time
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/mrf_if.sv]
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  slave_address;
   logic [15:0] register_address;
   logic [15:0] word_value;
   logic [6:0]  word_count;
   logic        last_word;

   modport source (output valid, operation, slave_address, register_address, word_value,
                   word_count, last_word, input ready);
   modport sink (input valid, operation, slave_address, register_address, word_value,
                 word_count, last_word, output ready);
endinterface

interface mrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_frame;

   modport source (output valid, frame_byte, end_of_frame, input ready);
   modport sink (input valid, frame_byte, end_of_frame, output ready);
endinterface

[rtl/core/mrf_front.sv]
module mrf_front
   import mrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   mrf_req_if.sink req_ch,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic   frame_open_ff, frame_open_in;
   logic   accept;
   op_type op;

   assign op            = op_type'(req_ch.operation);
   assign req_ch.ready  = push_ready;
   assign accept        = req_ch.valid && push_ready;
   // unused operation is taken and dropped
   assign push_valid    = req_ch.valid && (op != OP_UNUSED);

   always_comb begin
      push_cmd.slave = req_ch.slave_address;
      push_cmd.addr  = req_ch.register_address;
      push_cmd.word  = req_ch.word_value;
      push_cmd.count = req_ch.word_count;
      push_cmd.last  = req_ch.last_word;
      case (op)
         OP_READ_HOLDING: begin
            push_cmd.kind      = KIND_SINGLE;
            push_cmd.func_code = FUNC_READ_HOLDING;
         end
         OP_WRITE_SINGLE: begin
            push_cmd.kind      = KIND_SINGLE;
            push_cmd.func_code = FUNC_WRITE_SINGLE;
         end
         default: begin
            push_cmd.kind      = frame_open_ff ? KIND_MULTI_NEXT : KIND_MULTI_FIRST;
            push_cmd.func_code = FUNC_WRITE_MULTIPLE;
         end
      endcase
   end

   always_comb begin
      frame_open_in = frame_open_ff;
      if (accept) begin
         case (op)
            OP_READ_HOLDING, OP_WRITE_SINGLE: frame_open_in = 1'b0; // abandons open frame
            OP_WRITE_MULTIPLE:                frame_open_in = !req_ch.last_word;
            default:                          frame_open_in = frame_open_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

[rtl/core/mrf_queue.sv]
module mrf_queue
   import mrf_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            wr, rd;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign wr         = push_valid && push_ready;
   assign rd         = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(wr) - CntW'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/mrf_back.sv]
module mrf_back
   import mrf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   mrf_rsp_if.source rsp_ch
);

   step_type    step_ff, step_in;
   cmd_type     cur_ff, cur_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_eof_ff, out_eof_in;

   logic        adv;
   logic        last_step;
   logic [7:0]  step_byte;
   logic        step_eof;
   logic [15:0] step_crc;
   step_type    seq_next;
   logic        single;

   assign single    = (cur_ff.kind == KIND_SINGLE);
   assign adv       = (step_ff != STEP_IDLE) && (!out_valid_ff || rsp_ch.ready);
   assign pop_ready = (step_ff == STEP_IDLE) || (adv && last_step);

   // byte, CRC and successor for the current step
   always_comb begin
      step_byte = 8'h00;
      step_eof  = 1'b0;
      step_crc  = crc_ff;
      seq_next  = STEP_IDLE;
      last_step = 1'b0;
      case (step_ff)
         STEP_SLAVE: begin
            step_byte = cur_ff.slave;
            seq_next  = STEP_FUNC;
         end
         STEP_FUNC: begin
            step_byte = cur_ff.func_code;
            seq_next  = STEP_ADDR_HI;
         end
         STEP_ADDR_HI: begin
            step_byte = cur_ff.addr[15:8];
            seq_next  = STEP_ADDR_LO;
         end
         STEP_ADDR_LO: begin
            step_byte = cur_ff.addr[7:0];
            seq_next  = STEP_VALUE_HI;
         end
         STEP_VALUE_HI: begin
            step_byte = single ? cur_ff.word[15:8] : 8'h00;
            seq_next  = STEP_VALUE_LO;
         end
         STEP_VALUE_LO: begin
            step_byte = single ? cur_ff.word[7:0] : {1'b0, cur_ff.count};
            seq_next  = single ? STEP_CRC_LO : STEP_BYTE_COUNT;
         end
         STEP_BYTE_COUNT: begin
            step_byte = {cur_ff.count, 1'b0};
            seq_next  = STEP_DATA_HI;
         end
         STEP_DATA_HI: begin
            step_byte = cur_ff.word[15:8];
            seq_next  = STEP_DATA_LO;
         end
         STEP_DATA_LO: begin
            step_byte = cur_ff.word[7:0];
            seq_next  = cur_ff.last ? STEP_CRC_LO : STEP_IDLE;
            last_step = !cur_ff.last;
         end
         STEP_CRC_LO: begin
            step_byte = crc_ff[7:0];
            seq_next  = STEP_CRC_HI;
         end
         STEP_CRC_HI: begin
            step_byte = crc_ff[15:8];
            step_eof  = 1'b1;
            last_step = 1'b1;
         end
         default: begin
            step_byte = 8'h00;
         end
      endcase
      case (step_ff)
         STEP_IDLE, STEP_CRC_LO: step_crc = crc_ff;
         STEP_CRC_HI:            step_crc = CRC_INIT;
         STEP_SLAVE:             step_crc = crc_feed(CRC_INIT, step_byte); // new frame
         default:                step_crc = crc_feed(crc_ff, step_byte);
      endcase
   end

   // next state
   always_comb begin
      step_in = step_ff;
      cur_in  = cur_ff;
      if (pop_ready && pop_valid) begin
         cur_in  = pop_cmd;
         step_in = (pop_cmd.kind == KIND_MULTI_NEXT) ? STEP_DATA_HI : STEP_SLAVE;
      end else if (adv) begin
         step_in = seq_next;
      end
   end

   // output register and CRC
   always_comb begin
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      out_eof_in   = out_eof_ff;
      if (adv) begin
         crc_in       = step_crc;
         out_valid_in = 1'b1;
         out_byte_in  = step_byte;
         out_eof_in   = step_eof;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.frame_byte   = out_byte_ff;
   assign rsp_ch.end_of_frame = out_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_eof_ff  <= out_eof_in;
   end

endmodule

[rtl/core/modbus_rtu_request_framer.sv]
// Channel | Interface     | Transaction
// req_ch  | mrf_req_if    | one request word: operation, addresses, value, count, last flag
// rsp_ch  | mrf_rsp_if    | one frame byte in wire order, end_of_frame on the CRC high byte
//
// Bytes: the byte sequencer in mrf_back emits one frame byte per cycle while rsp_ch
// is not stalled; a transaction yields 8 bytes for a read or single write, 9 or 11
// for the first word of a multiple write, 2 or 4 for later words.
// A command popped while the sequencer sits idle is loaded before its first byte goes out.
// Reset: synchronous, clears the open-frame flag, the CRC to 0xFFFF, the queue.
// Stalls: the queue lets req_ch keep accepting while rsp_ch is held; req_ch.ready
// drops only when the queue is full. rsp_ch stalls freeze the output register.
module modbus_rtu_request_framer
   import mrf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_ch,
   mrf_rsp_if.source rsp_ch
);

   // front -> queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   // queue -> back
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // classifies each transaction and tracks whether a multiple write is open
   mrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples classification from byte emission
   mrf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // walks the byte sequence of each command, keeps the running CRC
   mrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

[rtl/core/mrf_checker.sv]
module mrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_eof
);

   logic [3:0] run_ff, run_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // bytes since the last frame end, saturating
   always_comb begin
      run_in = run_ff;
      if (rsp_take) begin
         if (rsp_eof) begin
            run_in = 4'd0;
         end else if (run_ff != 4'hF) begin
            run_in = run_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 4'd0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_min_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_eof) |-> (run_ff >= 4'd7))
      else $error("frame end after fewer than eight bytes");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_byte) && $stable(rsp_eof)))
      else $error("response payload changed while stalled");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_byte  (rsp_ch.frame_byte),
   .rsp_eof   (rsp_ch.end_of_frame)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mrf_pkg::*;

   // one request transaction as seen on req_ch
   typedef struct {
      op_type      op;
      logic [7:0]  slave;
      logic [15:0] addr;
      logic [15:0] word;
      logic [6:0]  count;
      logic        last;
   } request_type;

   // one frame byte as seen on rsp_ch
   typedef struct {
      logic [7:0] data;
      logic       eof;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrf_req_if req_if ();
   mrf_rsp_if rsp_if ();

   modbus_rtu_request_framer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // idle odds, percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // frame bytes still owed by the block, oldest first
   frame_byte_type bytes_due[$];

   // framer state mirror
   logic [15:0] frame_crc = CRC_INIT;
   logic        multi_open = 1'b0;

   int mismatch_count = 0;

   // ---------------------------------------------------------------------
   // Frame predictor
   // ---------------------------------------------------------------------

   // reflected CRC-16 (poly 0xA001), one byte, LSB first
   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void owe_byte(input logic [7:0] b, input logic eof);
      frame_byte_type fb;
      fb.data = b;
      fb.eof  = eof;
      bytes_due.push_back(fb);
   endfunction

   // payload byte: covered by the CRC
   function automatic void owe_data(input logic [7:0] b);
      frame_crc = crc16_next(frame_crc, b);
      owe_byte(b, 1'b0);
   endfunction

   // 16-bit fields go out big-endian
   function automatic void owe_word(input logic [15:0] w);
      owe_data(w[15:8]);
      owe_data(w[7:0]);
   endfunction

   // CRC trailer goes out little-endian, EOF on the high byte
   function automatic void owe_crc();
      owe_byte(frame_crc[7:0], 1'b0);
      owe_byte(frame_crc[15:8], 1'b1);
      frame_crc = CRC_INIT;
   endfunction

   function automatic void predict_frame_bytes(input request_type r);
      case (r.op)
         OP_READ_HOLDING, OP_WRITE_SINGLE: begin
            // complete frame on its own; drops any open multi-write frame
            multi_open = 1'b0;
            frame_crc  = CRC_INIT;
            owe_data(r.slave);
            owe_data(r.op == OP_READ_HOLDING ? FUNC_READ_HOLDING : FUNC_WRITE_SINGLE);
            owe_word(r.addr);
            owe_word(r.word);
            owe_crc();
         end
         OP_WRITE_MULTIPLE: begin
            // first word carries the header; later words ignore slave/addr/count
            if (!multi_open) begin
               frame_crc = CRC_INIT;
               owe_data(r.slave);
               owe_data(FUNC_WRITE_MULTIPLE);
               owe_word(r.addr);
               owe_word({9'd0, r.count});
               owe_data({r.count, 1'b0});
               multi_open = 1'b1;
            end
            owe_word(r.word);
            if (r.last) begin
               owe_crc();
               multi_open = 1'b0;
            end
         end
         default: ; // unused op: no bytes, no state change
      endcase
   endfunction

   // predict on every accepted request transaction
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         frame_crc  = CRC_INIT;
         multi_open = 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         r.op    = op_type'(req_if.operation);
         r.slave = req_if.slave_address;
         r.addr  = req_if.register_address;
         r.word  = req_if.word_value;
         r.count = req_if.word_count;
         r.last  = req_if.last_word;
         predict_frame_bytes(r);
      end
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (bytes_due.size() == 0) begin
            report_failure($sformatf("unexpected byte %02h eof %0b",
                                     rsp_if.frame_byte, rsp_if.end_of_frame));
         end else begin
            want = bytes_due.pop_front();
            if (want.data !== rsp_if.frame_byte || want.eof !== rsp_if.end_of_frame)
               report_failure($sformatf("byte expected %02h eof %0b, got %02h eof %0b",
                                        want.data, want.eof,
                                        rsp_if.frame_byte, rsp_if.end_of_frame));
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic request_type make_request(input op_type op, input logic [7:0] slave,
                                                input logic [15:0] addr,
                                                input logic [15:0] word,
                                                input logic [6:0] count, input logic last);
      request_type r;
      r.op    = op;
      r.slave = slave;
      r.addr  = addr;
      r.word  = word;
      r.count = count;
      r.last  = last;
      return r;
   endfunction

   function automatic request_type random_request(input op_type op);
      return make_request(op, 8'($urandom), 16'($urandom), 16'($urandom),
                          7'($urandom), 1'($urandom));
   endfunction

   // one request transaction; valid stays high on return so transactions
   // can follow back to back
   task automatic send_request(input request_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.operation        <= r.op;
      req_if.slave_address    <= r.slave;
      req_if.register_address <= r.addr;
      req_if.word_value       <= r.word;
      req_if.word_count       <= r.count;
      req_if.last_word        <= r.last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // hold off the sender until every owed byte is out, then settle
   task automatic wait_until_drained(input int settle);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // field extremes, all ops, abandon paths, count corner values
   task automatic test_directed_frames();
      send_request(make_request(OP_READ_HOLDING, 8'h00, 16'h0000, 16'h0000, 7'd0, 1'b0));
      // last flag on a read has no meaning
      send_request(make_request(OP_READ_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b1));
      send_request(make_request(OP_WRITE_SINGLE, 8'h01, 16'h1234, 16'hABCD, 7'd5, 1'b0));
      send_request(make_request(OP_WRITE_SINGLE, 8'hFF, 16'hFFFF, 16'h0000, 7'd1, 1'b1));
      // one-word multi-write: header, data and CRC from one transaction
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h11, 16'h0001, 16'h0A0B, 7'd1, 1'b1));
      // three-word frame; later words carry junk header fields
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h22, 16'h8000, 16'hFFFF, 7'd3, 1'b0));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'hFF, 16'hFFFF, 16'h0000, 7'h7F, 1'b0));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h00, 16'h0000, 16'h5A5A, 7'd0, 1'b1));
      // count corners: zero, max legal, out of range
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h05, 16'h0100, 16'h1111, 7'd0, 1'b1));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h06, 16'h0200, 16'h2222, 7'd123, 1'b1));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h07, 16'h0300, 16'h3333, 7'd127, 1'b1));
      // open frame dropped by a read
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h08, 16'h0400, 16'h4444, 7'd124, 1'b0));
      send_request(make_request(OP_READ_HOLDING, 8'h09, 16'h0500, 16'h007D, 7'd0, 1'b0));
      // open frame dropped by a single write
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h0A, 16'h0600, 16'h5555, 7'd2, 1'b0));
      send_request(make_request(OP_WRITE_SINGLE, 8'h0B, 16'h0700, 16'h6666, 7'd0, 1'b0));
      // unused op, alone and inside an open frame
      send_request(make_request(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b1));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h0C, 16'h0800, 16'h7777, 7'd2, 1'b0));
      send_request(make_request(OP_UNUSED, 8'h00, 16'h0000, 16'h0000, 7'd0, 1'b1));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h0D, 16'h0900, 16'h8888, 7'd9, 1'b1));
      // more words than the count says
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h0E, 16'h0A00, 16'h9999, 7'd1, 1'b0));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h0F, 16'h0B00, 16'hAAAA, 7'd1, 1'b0));
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h10, 16'h0C00, 16'hBBBB, 7'd1, 1'b1));
   endtask

   // open frame survives a fully idle block
   task automatic test_pause_until_drained();
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h31, 16'h4000, 16'hC0DE, 7'd2, 1'b0));
      wait_until_drained(20);
      send_request(make_request(OP_WRITE_MULTIPLE, 8'h00, 16'h0000, 16'hBEEF, 7'd0, 1'b1));
      send_request(make_request(OP_READ_HOLDING, 8'h32, 16'h4001, 16'h0010, 7'd0, 1'b0));
      wait_until_drained(20);
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random_traffic(input int n_items);
      int          sent;
      int          pick;
      int          words;
      request_type r;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            r = random_request(op_type'($urandom_range(0, 1)));
            send_request(r);
            sent++;
         end else if (pick < 85) begin
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int w = 0; w < words; w++) begin
               r = random_request(OP_WRITE_MULTIPLE);
               if (w == 0 && $urandom_range(0, 3) != 0) r.count = 7'(words);
               r.last = (w == words - 1);
               send_request(r);
               sent++;
            end
         end else if (pick < 93) begin
            // dangling word; whatever comes next continues or drops the frame
            r = random_request(OP_WRITE_MULTIPLE);
            r.last = 1'b0;
            send_request(r);
            sent++;
         end else begin
            // ignored by the block, not counted
            send_request(random_request(OP_UNUSED));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      req_if.valid            = 1'b0;
      req_if.operation        = OP_READ_HOLDING;
      req_if.slave_address    = '0;
      req_if.register_address = '0;
      req_if.word_value       = '0;
      req_if.word_count       = '0;
      req_if.last_word        = 1'b0;
      rsp_if.ready            = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 52;
      test_directed_frames();
      test_pause_until_drained();
      test_random_traffic(150);

      send_idle_pct = 52;
      recv_idle_pct = 24;
      test_random_traffic(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(150);

      // let the queue and the byte sequencer run dry; stray bytes show up here
      wait_until_drained(40);

      if (mismatch_count == 0 && bytes_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
